@@ sv/glv_pkg.sv @@
// Shared types and constants for the graded layer vertex offset block.
// No dependencies; used by glv_div and the top module (glv_place does not use it).
`timescale 1ns / 1ps
`default_nettype none
package glv_pkg;

    localparam int DVD_W = 64;   // divider dividend / quotient width
    localparam int DVS_W = 48;   // divider divisor width

    localparam logic [47:0] SUM_CAP = 48'h8000_0000_0000;  // 2^47
    localparam logic [47:0] ONE_Q16 = 48'h0000_0001_0000;

    localparam logic [1:0] CFG_THICKNESS = 2'd0;
    localparam logic [1:0] CFG_LAYERS    = 2'd1;
    localparam logic [1:0] CFG_GROWTH    = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_WACC  = 8'b0000_0010,
        ST_WDIV  = 8'b0000_0100,
        ST_S0DIV = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_SAT   = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_SDIV  = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

@@ sv/glv_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on glv_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module glv_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [glv_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [glv_pkg::DVS_W-1:0]  i_divisor,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [glv_pkg::DVD_W-1:0]       o_quot
);
    localparam int CW = $clog2(glv_pkg::DVD_W);

    logic [glv_pkg::DVD_W-1:0] r_dvd;   // dividend in, quotient shifts in at lsb
    logic [glv_pkg::DVS_W-1:0] r_dvs;
    logic [glv_pkg::DVS_W-1:0] r_rem;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [glv_pkg::DVS_W:0]   w_shift;
    logic [glv_pkg::DVS_W+1:0] w_diff;
    logic                      w_ge;

    assign w_shift = {r_rem, r_dvd[glv_pkg::DVD_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = ~w_diff[glv_pkg::DVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[glv_pkg::DVS_W-1:0] : w_shift[glv_pkg::DVS_W-1:0];
                r_dvd <= {r_dvd[glv_pkg::DVD_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule
`default_nettype wire

@@ sv/glv_place.sv @@
// Displacement unit: offset times normal component, rounded to Q16.16,
// subtracted from the node coordinate with saturation. No package use.
`timescale 1ns / 1ps
`default_nettype none
module glv_place (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [31:0]        i_offset,
    input  wire logic signed [15:0] i_normal,
    input  wire logic signed [31:0] i_node,
    output logic signed [31:0]      o_vertex
);
    logic signed [48:0] r_prod;
    logic signed [31:0] r_node;
    logic signed [49:0] w_q;
    logic signed [35:0] w_d;
    logic signed [36:0] w_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= $signed({1'b0, i_offset}) * i_normal;
            r_node <= i_node;
        end
    end

    assign w_q = 50'(r_prod) + 50'sd8192;
    assign w_d = 36'(w_q >>> 14);          // floor division by 2^14
    assign w_v = 37'(r_node) - 37'(w_d);

    always_comb begin
        if (w_v > 37'sh0_7FFF_FFFF)
            o_vertex = 32'sh7FFF_FFFF;
        else if (w_v < -37'sh0_8000_0000)
            o_vertex = 32'sh8000_0000;
        else
            o_vertex = w_v[31:0];
    end
endmodule
`default_nettype wire

@@ sv/graded_layer_vertex_offsets_top.sv @@
// Graded boundary-layer vertex generator: per node, n vertices pushed along the normal.
// Each node runs on the shared serial divider: n-1 weight divisions, one first-step
// division, then n-1 step divisions; each layer takes the three axes in turn through
// the MUL and SAT states before its vertex is emitted.
// A new node is taken only when the previous one is done; input ready only when idle.
// Sync active-low reset restores config defaults and clears control. Uses glv_pkg, glv_div, glv_place.
`timescale 1ns / 1ps
`default_nettype none
module graded_layer_vertex_offsets_top #(
    parameter int MAX_LAYERS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config write port
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [30:0]  i_cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // node_x[31:0] node_y[63:32] node_z[95:64] normal_x[111:96]
    // normal_y[127:112] normal_z[143:128]
    input  wire logic [143:0] s_axis_tdata,
    // output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // layer_index[3:0] vertex_x[35:4] vertex_y[67:36] vertex_z[99:68] zero[103:100]
    output logic [103:0]      m_axis_tdata,
    output logic              m_axis_tlast    // last_layer
);
    localparam int JW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

    // config registers
    logic [30:0] r_thick;
    logic [4:0]  r_layers;
    logic [23:0] r_growth;

    // per-node working state
    glv_pkg::t_state r_state;
    logic [JW-1:0]      r_j;
    logic [JW-1:0]      r_nm1;
    logic [23:0]        r_b;
    logic [47:0]        r_p;
    logic [47:0]        r_sum;
    logic [31:0]        r_s;
    logic [31:0]        r_acc;
    logic [1:0]         r_k;
    logic signed [31:0] r_node [3];
    logic signed [15:0] r_nrm  [3];
    logic signed [31:0] r_vtx  [3];
    logic               r_out_valid;

    // layer count clamp: zero means one, cap at MAX_LAYERS
    logic [7:0]  w_lc;
    logic [7:0]  w_nm1;
    always_comb begin
        w_lc = (r_layers == 5'd0) ? 8'd1 : {3'b000, r_layers};
        if (w_lc > 8'(MAX_LAYERS))
            w_lc = 8'(MAX_LAYERS);
        w_nm1 = w_lc - 8'd1;
    end

    // running weight sum, saturating
    logic [48:0] w_sum_raw;
    logic [47:0] w_sum_n;
    assign w_sum_raw = {1'b0, r_sum} + {1'b0, r_p};
    assign w_sum_n   = (w_sum_raw > {1'b0, glv_pkg::SUM_CAP}) ? glv_pkg::SUM_CAP
                                                              : w_sum_raw[47:0];

    logic w_out_xfer;
    logic w_last;
    assign w_out_xfer = r_out_valid && m_axis_tready;
    assign w_last     = (r_j == r_nm1);

    // shared divider
    logic                      w_div_start;
    logic [glv_pkg::DVD_W-1:0] w_div_dvd;
    logic [glv_pkg::DVS_W-1:0] w_div_dvs;
    logic                      w_div_busy;
    logic                      w_div_done;
    logic [glv_pkg::DVD_W-1:0] w_quot;

    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = {r_p, 16'h0000};
        w_div_dvs   = {24'h000000, r_b};
        if (r_state == glv_pkg::ST_WACC) begin
            w_div_start = 1'b1;
            if (w_last) begin
                w_div_dvd = {17'h0, r_thick, 16'h0000};
                w_div_dvs = w_sum_n;
            end
        end else if (r_state == glv_pkg::ST_EMIT && w_out_xfer && !w_last) begin
            w_div_start = 1'b1;
            w_div_dvd   = {16'h0000, r_s, 16'h0000};
        end
    end

    glv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // later step and cumulative offset, both saturating at 32 bits
    logic [31:0] w_s_n;
    logic [32:0] w_acc_raw;
    logic [31:0] w_acc_n;
    assign w_s_n     = (w_quot[63:32] != 32'h0) ? 32'hFFFF_FFFF : w_quot[31:0];
    assign w_acc_raw = {1'b0, r_acc} + {1'b0, w_s_n};
    assign w_acc_n   = w_acc_raw[32] ? 32'hFFFF_FFFF : w_acc_raw[31:0];

    // shared multiplier, one axis per pass
    logic signed [31:0] w_vertex;
    glv_place u_place (
        .i_clk    (i_clk),
        .i_en     (r_state == glv_pkg::ST_MUL),
        .i_offset (r_acc),
        .i_normal (r_nrm[r_k]),
        .i_node   (r_node[r_k]),
        .o_vertex (w_vertex)
    );

    logic w_in_xfer;
    assign s_axis_tready = (r_state == glv_pkg::ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thick     <= 31'd65536;
            r_layers    <= 5'd1;
            r_growth    <= 24'd65536;
            r_state     <= glv_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_j         <= '0;
            r_k         <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    glv_pkg::CFG_THICKNESS: r_thick  <= i_cfg_data;
                    glv_pkg::CFG_LAYERS:    r_layers <= i_cfg_data[4:0];
                    glv_pkg::CFG_GROWTH:    r_growth <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                glv_pkg::ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_node[0] <= s_axis_tdata[31:0];
                        r_node[1] <= s_axis_tdata[63:32];
                        r_node[2] <= s_axis_tdata[95:64];
                        r_nrm[0]  <= s_axis_tdata[111:96];
                        r_nrm[1]  <= s_axis_tdata[127:112];
                        r_nrm[2]  <= s_axis_tdata[143:128];
                        r_nm1     <= w_nm1[JW-1:0];
                        r_b       <= (r_growth == 24'd0) ? 24'd65536 : r_growth;
                        r_p       <= glv_pkg::ONE_Q16;
                        r_sum     <= '0;
                        r_j       <= '0;
                        r_state   <= glv_pkg::ST_WACC;
                    end
                end
                glv_pkg::ST_WACC: begin
                    r_sum   <= w_sum_n;
                    r_state <= w_last ? glv_pkg::ST_S0DIV : glv_pkg::ST_WDIV;
                end
                glv_pkg::ST_WDIV: begin
                    if (w_div_done) begin
                        r_p     <= (w_quot > {16'h0, glv_pkg::SUM_CAP}) ? glv_pkg::SUM_CAP
                                                                        : w_quot[47:0];
                        r_j     <= r_j + 1'b1;
                        r_state <= glv_pkg::ST_WACC;
                    end
                end
                glv_pkg::ST_S0DIV: begin
                    if (w_div_done) begin
                        r_s     <= w_quot[31:0];
                        r_acc   <= w_quot[31:0];
                        r_j     <= '0;
                        r_k     <= 2'd0;
                        r_state <= glv_pkg::ST_MUL;
                    end
                end
                glv_pkg::ST_MUL: begin
                    r_state <= glv_pkg::ST_SAT;
                end
                glv_pkg::ST_SAT: begin
                    r_vtx[r_k] <= w_vertex;
                    if (r_k == 2'd2) begin
                        r_out_valid <= 1'b1;
                        r_state     <= glv_pkg::ST_EMIT;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= glv_pkg::ST_MUL;
                    end
                end
                glv_pkg::ST_EMIT: begin
                    if (w_out_xfer) begin
                        r_out_valid <= 1'b0;
                        r_state     <= w_last ? glv_pkg::ST_IDLE : glv_pkg::ST_SDIV;
                    end
                end
                glv_pkg::ST_SDIV: begin
                    if (w_div_done) begin
                        r_s     <= w_s_n;
                        r_acc   <= w_acc_n;
                        r_j     <= r_j + 1'b1;
                        r_k     <= 2'd0;
                        r_state <= glv_pkg::ST_MUL;
                    end
                end
                default: r_state <= glv_pkg::ST_IDLE;
            endcase
        end
    end

    logic [JW+3:0] w_jx;
    assign w_jx = {4'h0, r_j};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = w_last;
    assign m_axis_tdata  = {4'h0, r_vtx[2], r_vtx[1], r_vtx[0], w_jx[3:0]};

    // checks
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == glv_pkg::ST_EMIT))
        else $error("result valid outside emit state");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == glv_pkg::ST_IDLE) |-> !w_div_busy)
        else $error("divider busy while idle");
    a_acc_ge_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == glv_pkg::ST_MUL) |-> (r_acc >= r_s))
        else $error("offset below current step");
endmodule
`default_nettype wire
